### hdl/bitmap_index_containment_top_assert.svh
// Assertion macros for the checker file of the bitmap index block.
`ifndef BITMAP_INDEX_CONTAINMENT_TOP_ASSERT_SVH
`define BITMAP_INDEX_CONTAINMENT_TOP_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define BIC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define BIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/bic_pkg.sv
`timescale 1ns / 1ps

package bic_pkg;

  // Default geometry of the index
  localparam int NUM_TRANSACTIONS_DEF = 64;
  localparam int NUM_ITEMS_DEF        = 1024;

  // Fixed field widths
  localparam int OPCODE_W   = 2;
  localparam int ITEM_ID_W  = 10;
  localparam int TXN_ID_W   = 6;
  localparam int TAG_W      = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RMW,
    ST_EMIT
  } state_e;

endpackage

### hdl/bic_ram.sv
`timescale 1ns / 1ps

module bic_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bitmap_index_containment_top.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// command   start / busy         opcode_i, item_id_i, transaction_id_i, query_end_i, query_tag_i
// result    out_valid_o strobe   match_id_o, match_valid_o, result_tag_o, last_o
//
// Insert and query beats read the bitmap RAM, then write back (insert) or accumulate
// (query) in ST_RMW. Opcode three and an out-of-range insert stay in ST_IDLE. A query's
// final beat emits one result beat per matching transaction from ST_EMIT, or one no-match
// beat from ST_RMW. Reset sweeps all NUM_ITEMS words (1024 by default) of the bitmap RAM
// with busy high; a clear beat runs the same sweep. The accumulator returns to all ones at
// once. Results are strobed for one cycle each; the receiver cannot stall.

module bitmap_index_containment_top #(
  parameter int NUM_TRANSACTIONS = bic_pkg::NUM_TRANSACTIONS_DEF,
  parameter int NUM_ITEMS        = bic_pkg::NUM_ITEMS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bic_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [bic_pkg::ITEM_ID_W-1:0] item_id_i,
  input  logic [bic_pkg::TXN_ID_W-1:0]  transaction_id_i,
  input  logic                          query_end_i,
  input  logic [bic_pkg::TAG_W-1:0]     query_tag_i,
  output logic                          out_valid_o,
  output logic [bic_pkg::TXN_ID_W-1:0]  match_id_o,
  output logic                          match_valid_o,
  output logic [bic_pkg::TAG_W-1:0]     result_tag_o,
  output logic                          last_o
);
  import bic_pkg::*;

  localparam int AW = $clog2(NUM_ITEMS);
  localparam int W  = NUM_TRANSACTIONS;

  state_e             state_q, state_d;
  logic [AW-1:0]      sweep_q, sweep_d;
  logic [W-1:0]       acc_q, acc_d;
  logic [W-1:0]       hits_q, hits_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [TXN_ID_W-1:0] txn_q, txn_d;
  logic               ins_q, ins_d;
  logic               qend_q, qend_d;
  logic               range_q, range_d;
  logic [TAG_W-1:0]   tag_q, tag_d;

  logic               out_valid_q, out_valid_d;
  logic [TXN_ID_W-1:0] match_id_q, match_id_d;
  logic               match_valid_q, match_valid_d;
  logic [TAG_W-1:0]   result_tag_q, result_tag_d;
  logic               last_q, last_d;

  logic               accept;
  logic [31:0]        item_ext;
  logic               item_ok;
  logic               txn_ok;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [W-1:0]       ram_wdata;
  logic [W-1:0]       ram_rdata;
  logic [W-1:0]       new_acc;
  logic [W-1:0]       low_bit;
  logic [W-1:0]       rest;
  logic [TXN_ID_W-1:0] low_idx;

  assign accept   = start && !busy;
  assign item_ext = 32'(item_id_i);
  assign item_ok  = item_ext < 32'(NUM_ITEMS);
  assign txn_ok   = 32'(transaction_id_i) < 32'(NUM_TRANSACTIONS);

  // Bitmap store
  bic_ram #(
    .WIDTH (W),
    .DEPTH (NUM_ITEMS)
  ) u_bic_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (item_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Narrow the surviving set to its lowest member
  always_comb begin
    low_bit = hits_q & (~hits_q + W'(1));
    rest    = hits_q & ~low_bit;
    low_idx = '0;
    for (int t = 0; t < W; t++) begin
      if (low_bit[t]) begin
        low_idx = low_idx | TXN_ID_W'(t);
      end
    end
  end

  assign new_acc = acc_q & (range_q ? ram_rdata : '0);

  // Sequencer: next state, RAM controls and result beat
  always_comb begin
    state_d       = state_q;
    sweep_d       = sweep_q;
    acc_d         = acc_q;
    hits_d        = hits_q;
    addr_d        = addr_q;
    txn_d         = txn_q;
    ins_d         = ins_q;
    qend_d        = qend_q;
    range_d       = range_q;
    tag_d         = tag_q;
    out_valid_d   = 1'b0;
    match_id_d    = match_id_q;
    match_valid_d = match_valid_q;
    result_tag_d  = result_tag_q;
    last_d        = last_q;
    ram_we        = 1'b0;
    ram_waddr     = addr_q;
    ram_wdata     = '0;

    unique case (state_q)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        sweep_d   = sweep_q + AW'(1);
        if (sweep_q == AW'(NUM_ITEMS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          addr_d  = item_ext[AW-1:0];
          txn_d   = transaction_id_i;
          qend_d  = query_end_i;
          range_d = item_ok;
          tag_d   = query_tag_i;
          unique case (op_e'(opcode_i))
            OP_CLEAR: begin
              acc_d   = '1;
              sweep_d = '0;
              state_d = ST_SWEEP;
            end
            OP_INSERT: begin
              ins_d = 1'b1;
              if (item_ok && txn_ok) begin
                state_d = ST_RMW;
              end
            end
            OP_QUERY: begin
              ins_d   = 1'b0;
              state_d = ST_RMW;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RMW: begin
        state_d = ST_IDLE;
        if (ins_q) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (W'(1) << txn_q);
        end else if (!qend_q) begin
          acc_d = new_acc;
        end else begin
          acc_d        = '1;
          result_tag_d = tag_q;
          if (new_acc == '0) begin
            // no transaction survived: one no-match beat
            out_valid_d   = 1'b1;
            match_id_d    = '0;
            match_valid_d = 1'b0;
            last_d        = 1'b1;
          end else begin
            hits_d  = new_acc;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid_d   = 1'b1;
        match_id_d    = low_idx;
        match_valid_d = 1'b1;
        last_d        = (rest == '0);
        hits_d        = rest;
        if (rest == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      acc_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hits_q        <= hits_d;
    addr_q        <= addr_d;
    txn_q         <= txn_d;
    ins_q         <= ins_d;
    qend_q        <= qend_d;
    range_q       <= range_d;
    tag_q         <= tag_d;
    match_id_q    <= match_id_d;
    match_valid_q <= match_valid_d;
    result_tag_q  <= result_tag_d;
    last_q        <= last_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign match_id_o    = match_id_q;
  assign match_valid_o = match_valid_q;
  assign result_tag_o  = result_tag_q;
  assign last_o        = last_q;

endmodule

### hdl/bic_assert.sv
`timescale 1ns / 1ps
`include "bitmap_index_containment_top_assert.svh"

module bic_assert (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [bic_pkg::OPCODE_W-1:0]  opcode_i,
  input logic [bic_pkg::ITEM_ID_W-1:0] item_id_i,
  input logic [bic_pkg::TXN_ID_W-1:0]  transaction_id_i,
  input logic                          query_end_i,
  input logic [bic_pkg::TAG_W-1:0]     query_tag_i,
  input logic                          out_valid_o,
  input logic [bic_pkg::TXN_ID_W-1:0]  match_id_o,
  input logic                          match_valid_o,
  input logic [bic_pkg::TAG_W-1:0]     result_tag_o,
  input logic                          last_o
);
  import bic_pkg::*;

  // In the cycle after reset is seen, the block is busy with no result beat
  `BIC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> (busy && !out_valid_o), "reset not quiet")

  // A no-match beat is always the final beat of its query
  `BIC_ASSERT(a_nomatch_last, clk_i, rst_ni, (out_valid_o && !match_valid_o) |-> last_o,
    "no-match beat without last")

  // Matches of one query follow back to back, ascending, with one tag
  `BIC_ASSERT(a_ascending, clk_i, rst_ni, (out_valid_o && match_valid_o && !last_o) |=>
    (out_valid_o && match_valid_o && (match_id_o > $past(match_id_o)) &&
     (result_tag_o == $past(result_tag_o))), "match beats out of order")

  // A query beat occupies the block for its accumulate cycle, with no result yet
  `BIC_ASSERT(a_query_rmw, clk_i, rst_ni, (start && !busy && (opcode_i == OP_QUERY)) |=>
    (busy && !out_valid_o), "query beat skipped its accumulate cycle")

endmodule

bind bitmap_index_containment_top bic_assert u_bic_assert (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import bic_pkg::*;

  localparam int NUM_TRANSACTIONS = NUM_TRANSACTIONS_DEF;
  localparam int NUM_ITEMS        = NUM_ITEMS_DEF;
  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
  localparam logic [63:0] TXN_MASK = {64{1'b1}} >> (64 - NUM_TRANSACTIONS);
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [OPCODE_W-1:0]  opcode;
    logic [ITEM_ID_W-1:0] item;
    logic [TXN_ID_W-1:0]  txn;
    logic                 qend;
    logic [TAG_W-1:0]     tag;
    bit                   drain;
  } cmd_t;

  typedef struct packed {
    logic [TXN_ID_W-1:0] id;
    logic                valid;
    logic [TAG_W-1:0]    tag;
    logic                last;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OPCODE_W-1:0]  opcode_i = '0;
  logic [ITEM_ID_W-1:0] item_id_i = '0;
  logic [TXN_ID_W-1:0]  transaction_id_i = '0;
  logic                 query_end_i = 1'b0;
  logic [TAG_W-1:0]     query_tag_i = '0;
  logic                 out_valid_o;
  logic [TXN_ID_W-1:0]  match_id_o;
  logic                 match_valid_o;
  logic [TAG_W-1:0]     result_tag_o;
  logic                 last_o;

  // Shadow copy of the index
  logic [63:0] bitmap_mem [NUM_ITEMS];
  logic [63:0] query_acc;

  cmd_t   cmd_q[$];
  match_t match_q[$];
  cmd_t   cur_cmd;

  int n_planned;
  int n_accepted;
  int n_queries;
  int n_results;
  int n_hits;
  int n_errors;

  bitmap_index_containment_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .item_id_i        (item_id_i),
    .transaction_id_i (transaction_id_i),
    .query_end_i      (query_end_i),
    .query_tag_i      (query_tag_i),
    .out_valid_o      (out_valid_o),
    .match_id_o       (match_id_o),
    .match_valid_o    (match_valid_o),
    .result_tag_o     (result_tag_o),
    .last_o           (last_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // Append one expected result beat
  task automatic expect_match(input match_t m);
    match_q.insert(match_q.size(), m);
  endtask

  // Apply one accepted beat to the shadow index and queue the matches it produces
  task automatic index_apply(input cmd_t c);
    logic [63:0] hits;
    case (c.opcode)
      OP_CLEAR: begin
        foreach (bitmap_mem[i]) bitmap_mem[i] = '0;
        query_acc = TXN_MASK;
      end
      OP_INSERT: begin
        if (c.item < NUM_ITEMS && c.txn < NUM_TRANSACTIONS)
          bitmap_mem[c.item][c.txn] = 1'b1;
      end
      OP_QUERY: begin
        if (c.item < NUM_ITEMS) query_acc &= bitmap_mem[c.item];
        else query_acc = '0;
        query_acc &= TXN_MASK;
        if (c.qend) begin
          hits = query_acc;
          query_acc = TXN_MASK;
          n_queries++;
          if (hits == '0) begin
            expect_match('{id: '0, valid: 1'b0, tag: c.tag, last: 1'b1});
          end else begin
            for (int t = 0; t < NUM_TRANSACTIONS; t++) begin
              if (hits[t]) begin
                hits[t] = 1'b0;
                expect_match('{id: t[TXN_ID_W-1:0], valid: 1'b1, tag: c.tag,
                               last: (hits == '0)});
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_cmd(input logic [OPCODE_W-1:0] op, input int item, input int txn,
                          input bit qend, input int tag, input bit drain);
    cmd_t c;
    c.opcode = op;
    c.item   = item[ITEM_ID_W-1:0];
    c.txn    = txn[TXN_ID_W-1:0];
    c.qend   = qend;
    c.tag    = tag[TAG_W-1:0];
    c.drain  = drain;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  // Driver: note the accepted beat, then decide whether to offer the next one
  always @(posedge clk_i) begin
    int  idle_pct;
    bit  go;
    if (rst_ni) begin
      if (start && !busy) begin
        index_apply(cur_cmd);
        n_accepted++;
      end
      if (!start || !busy) begin
        go = 1'b0;
        if (n_accepted < n_planned / 3) idle_pct = 30;
        else if (n_accepted < 2 * n_planned / 3) idle_pct = 64;
        else idle_pct = 0;
        if (cmd_q.size() > 0) begin
          if (cmd_q[0].drain && match_q.size() != 0) go = 1'b0;
          else go = ($urandom_range(99) >= idle_pct);
        end
        if (go) begin
          cur_cmd = cmd_q.pop_front();
          opcode_i         <= cur_cmd.opcode;
          item_id_i        <= cur_cmd.item;
          transaction_id_i <= cur_cmd.txn;
          query_end_i      <= cur_cmd.qend;
          query_tag_i      <= cur_cmd.tag;
          start            <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expected match
  always @(posedge clk_i) begin
    match_t got;
    match_t want;
    if (rst_ni && out_valid_o) begin
      got = '{id: match_id_o, valid: match_valid_o, tag: result_tag_o, last: last_o};
      n_results++;
      if (got.valid) n_hits++;
      if (match_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result id %0d valid %b tag %0d last %b",
                                  got.id, got.valid, got.tag, got.last));
      end else begin
        want = match_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("got id %0d valid %b tag %0d last %b, %s",
                                    got.id, got.valid, got.tag, got.last,
                                    $sformatf("want id %0d valid %b tag %0d last %b",
                                              want.id, want.valid, want.tag, want.last)));
      end
    end
  end

  // Stimulus plan, reset and end of run
  initial begin
    int pool [4];
    int txns [8];
    int kind;
    int n_ins;
    int n_qry;
    int seq;
    bit drain;

    foreach (bitmap_mem[i]) bitmap_mem[i] = '0;
    query_acc = TXN_MASK;

    // Directed: never-inserted item, extreme ids and tags, reserved opcode,
    // empty item mid-query, clear during a query
    push_cmd(OP_QUERY,    0,    0,  1, 'h00, 0);
    push_cmd(OP_INSERT,   0,    0,  0, 'h00, 0);
    push_cmd(OP_INSERT,   0,    63, 0, 'h00, 0);
    push_cmd(OP_INSERT,   1023, 63, 0, 'hFF, 0);
    push_cmd(OP_INSERT,   1023, 0,  1, 'hFF, 0);
    push_cmd(OP_INSERT,   1023, 42, 0, 'h00, 0);
    push_cmd(OP_QUERY,    0,    0,  1, 'hFF, 0);
    push_cmd(OP_QUERY,    0,    63, 0, 'h01, 0);
    push_cmd(OP_QUERY,    1023, 0,  1, 'hA5, 0);
    push_cmd(OP_RESERVED, 1023, 63, 1, 'hFF, 0);
    push_cmd(OP_QUERY,    1023, 0,  1, 'h5A, 1);
    push_cmd(OP_QUERY,    512,  0,  0, 'h00, 0);
    push_cmd(OP_QUERY,    0,    0,  1, 'h80, 0);
    push_cmd(OP_QUERY,    1023, 0,  0, 'h11, 0);
    push_cmd(OP_CLEAR,    1023, 63, 1, 'hFF, 1);
    push_cmd(OP_INSERT,   1023, 21, 0, 'h00, 0);
    push_cmd(OP_QUERY,    1023, 0,  1, 'h03, 0);
    push_cmd(OP_QUERY,    0,    0,  1, 'h7F, 0);
    push_cmd(OP_INSERT,   682,  21, 0, 'h00, 0);
    push_cmd(OP_QUERY,    341,  0,  1, 'h3C, 0);
    push_cmd(OP_QUERY,    682,  0,  1, 'hC3, 0);

    // Random: mostly insert-then-query sequences over a small item and
    // transaction pool, with noise, broken queries and the odd full bitmap
    seq = 0;
    while (cmd_q.size() < 465) begin
      foreach (pool[i]) pool[i] = $urandom_range(NUM_ITEMS - 1);
      foreach (txns[i]) txns[i] = $urandom_range(NUM_TRANSACTIONS - 1);
      drain = ($urandom_range(9) == 0);
      kind = $urandom_range(99);
      if (seq == 3 || $urandom_range(39) == 0) begin
        // every transaction holds the item: longest match list
        for (int t = 0; t < NUM_TRANSACTIONS; t++)
          push_cmd(OP_INSERT, pool[0], t, 1'($urandom_range(1)), $urandom,
                   (t == 0) && drain);
        push_cmd(OP_QUERY, pool[0], $urandom, 1, $urandom, 0);
      end else if (kind < 80) begin
        n_ins = $urandom_range(8, 1);
        for (int i = 0; i < n_ins; i++)
          push_cmd(OP_INSERT, pool[2'($urandom_range(3))], txns[3'($urandom_range(7))],
                   1'($urandom_range(1)), $urandom, (i == 0) && drain);
        n_qry = $urandom_range(3, 1);
        for (int i = 0; i < n_qry; i++)
          push_cmd(OP_QUERY, pool[2'($urandom_range(3))], $urandom, (i == n_qry - 1),
                   $urandom, 0);
      end else if (kind < 92) begin
        // noise: any opcode, any field
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(15) == 0)
            push_cmd(OP_CLEAR, $urandom, $urandom, 1'($urandom_range(1)), $urandom, drain);
          else if ($urandom_range(1))
            push_cmd(OP_RESERVED, $urandom, $urandom, 1'($urandom_range(1)), $urandom,
                     drain);
          else
            push_cmd(OPCODE_W'($urandom_range(2, 1)), $urandom, $urandom,
                     1'($urandom_range(1)), $urandom, drain);
        end
      end else begin
        // broken query: interrupted by a clear or by inserts
        push_cmd(OP_QUERY, pool[0], $urandom, 0, $urandom, drain);
        if ($urandom_range(1)) push_cmd(OP_CLEAR, $urandom, $urandom, 1'($urandom_range(1)),
                                        $urandom, 0);
        else push_cmd(OP_INSERT, pool[1], txns[0], 1, $urandom, 0);
        push_cmd(OP_INSERT, pool[1], txns[1], 0, $urandom, 0);
        push_cmd(OP_QUERY, pool[1], $urandom, 1, $urandom, 0);
      end
      seq++;
    end
    n_planned = cmd_q.size();

    // Hold reset, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to be taken, then for the match list to drain
    do @(negedge clk_i); while (cmd_q.size() != 0 || start);
    while (match_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (match_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", match_q.size()));

    $display("Run covered %0d command beats, %0d completed queries, %0d results (%0d matches).",
             n_accepted, n_queries, n_results, n_hits);
    $display("Clears, broken queries, reserved opcodes and full bitmaps included; %0d mismatches.",
             n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #2000000;
    $display("Timeout waiting for the block to finish");
    $display("Test completed with failures");
    $finish;
  end

endmodule
